@@ rtl/esup_pkg.sv @@
package esup_pkg;

    localparam int unsigned MaxParamsDefault = 16;

    typedef enum logic [2:0] {
        EV_PRINT    = 3'd0,
        EV_CONTROL  = 3'd1,
        EV_CSI      = 3'd2,
        EV_ESC      = 3'd3,
        EV_HASH     = 3'd4,
        EV_OSC_BYTE = 3'd5,
        EV_OSC_END  = 3'd6,
        EV_OSC_ABRT = 3'd7
    } t_kind;

    typedef enum logic [9:0] {
        ST_NORMAL = 10'b0000000001,
        ST_U1     = 10'b0000000010,
        ST_U2     = 10'b0000000100,
        ST_U3     = 10'b0000001000,
        ST_ESC    = 10'b0000010000,
        ST_HASH   = 10'b0000100000,
        ST_OSC    = 10'b0001000000,
        ST_OSC_ST = 10'b0010000000,
        ST_PARAM  = 10'b0100000000,
        ST_INTER  = 10'b1000000000
    } t_state;

    // Front-to-back command: either a single event or a CSI run request.
    typedef struct packed {
        logic        run;
        t_kind       kind;
        logic [20:0] char_val;
        logic [7:0]  cmd_byte;
        logic        query;
        logic [4:0]  total;
    } t_cmd;

    typedef struct packed {
        t_kind       kind;
        logic [20:0] char_val;
        logic [7:0]  cmd_byte;
        logic        query;
        logic [3:0]  index;
        logic [15:0] value;
        logic [4:0]  total;
        logic        last;
    } t_evt;

endpackage

@@ rtl/escape_sequence_utf8_parser.sv @@
// Terminal byte parser: one byte per cycle in while full is low; UTF-8, control, escape,
// hash and OSC events come out in the next cycle through a one-entry output register. A
// CSI final byte with stored parameters holds the input (full) while the back end reads
// the parameter RAM one entry at a time and emits one result per stored parameter.
module escape_sequence_utf8_parser #(
    parameter int unsigned MAX_PARAMS = esup_pkg::MaxParamsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_event_kind,
    output logic [20:0] o_char_val,
    output logic [7:0]  o_cmd_byte,
    output logic        o_query_flag,
    output logic [3:0]  o_param_index,
    output logic [15:0] o_param_value,
    output logic [4:0]  o_param_total,
    output logic        o_last_of_run
);
    logic           cmd_valid, busy, we, evt_valid;
    esup_pkg::t_cmd cmd;
    esup_pkg::t_evt evt;
    logic [3:0]     waddr, raddr;
    logic [15:0]    wdata, rdata;

    assign full = busy;

    esup_front #(.MAX_PARAMS(MAX_PARAMS)) u_front (
        .i_clk, .i_rst_n, .i_valid(push), .i_byte(i_in_byte), .i_stall(busy),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .o_we(we), .o_waddr(waddr), .o_wdata(wdata)
    );

    esup_ram #(.WIDTH(16), .DEPTH(16)) u_ram (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata), .i_raddr(raddr), .o_rdata(rdata)
    );

    esup_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_busy(busy),
        .o_raddr(raddr), .i_rdata(rdata), .i_out_ready(pop), .o_evt_valid(evt_valid),
        .o_evt(evt)
    );

    assign empty         = !evt_valid;
    assign o_event_kind  = evt.kind;
    assign o_char_val    = evt.char_val;
    assign o_cmd_byte    = evt.cmd_byte;
    assign o_query_flag  = evt.query;
    assign o_param_index = evt.index;
    assign o_param_value = evt.value;
    assign o_param_total = evt.total;
    assign o_last_of_run = evt.last;

    a_run_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_event_kind == esup_pkg::EV_CSI && o_last_of_run && o_param_total != 0)
        |-> (5'(o_param_index) + 5'd1 == o_param_total))
        else $error("last index mismatch");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_event_kind)))
        else $error("result lost");
endmodule

@@ rtl/esup_ram.sv @@
module esup_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/esup_front.sv @@
module esup_front #(
    parameter int unsigned MAX_PARAMS = esup_pkg::MaxParamsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic               i_stall,
    output logic               o_cmd_valid,
    output esup_pkg::t_cmd     o_cmd,
    output logic               o_we,
    output logic [3:0]         o_waddr,
    output logic [15:0]        o_wdata
);
    localparam int unsigned Cap = (MAX_PARAMS < 16) ? MAX_PARAMS : 16;

    esup_pkg::t_state r_state, n_state;
    logic [20:0] r_cp, n_cp;
    logic        r_swallow, n_swallow, r_q, n_q, r_first, n_first;
    logic [15:0] r_val, n_val;
    logic        r_dig, n_dig, r_bad, n_bad;
    logic [4:0]  r_cnt, n_cnt;
    logic [19:0] mul;
    logic        take;
    logic        close_req;
    logic [4:0]  cnt_closed;

    assign take = i_valid && !i_stall;

    always_comb begin
        mul = {4'd0, r_val} * 20'd10 + {16'd0, i_byte[3:0]};
    end

    always_comb begin
        logic [7:0] ch;
        logic       norm;
        ch = i_byte;
        n_state = r_state; n_cp = r_cp; n_swallow = r_swallow; n_q = r_q;
        n_first = r_first; n_val = r_val; n_dig = r_dig; n_bad = r_bad; n_cnt = r_cnt;
        o_cmd_valid = 1'b0;
        o_cmd = '0;
        close_req = 1'b0;
        norm = 1'b0;
        cnt_closed = r_cnt;
        if (r_dig && r_cnt < 5'(Cap)) begin
            cnt_closed = r_cnt + 5'd1;
        end
        case (r_state)
            esup_pkg::ST_ESC: begin
                n_state = esup_pkg::ST_NORMAL;
                if (ch == "[" || ch == "(") begin
                    if (ch == "(") n_swallow = 1'b1;
                    n_q = 1'b0; n_first = 1'b1; n_val = '0; n_dig = 1'b0;
                    n_bad = 1'b0; n_cnt = '0;
                    n_state = esup_pkg::ST_PARAM;
                end else if (ch == "]") begin
                    n_state = esup_pkg::ST_OSC;
                end else if (ch == "#") begin
                    n_state = esup_pkg::ST_HASH;
                end else if (ch == "D" || ch == "M" || ch == "E") begin
                    o_cmd_valid = 1'b1; o_cmd.kind = esup_pkg::EV_ESC; o_cmd.cmd_byte = ch;
                end
            end
            esup_pkg::ST_HASH: begin
                if (ch inside {["0":"9"]}) begin
                    n_state = esup_pkg::ST_NORMAL;
                    o_cmd_valid = 1'b1; o_cmd.kind = esup_pkg::EV_HASH; o_cmd.cmd_byte = ch;
                end
            end
            esup_pkg::ST_OSC: begin
                if (ch == 8'd27) begin
                    n_state = esup_pkg::ST_OSC_ST;
                end else if (ch == 8'd7) begin
                    n_state = esup_pkg::ST_NORMAL;
                    o_cmd_valid = 1'b1; o_cmd.kind = esup_pkg::EV_OSC_END;
                end else begin
                    o_cmd_valid = 1'b1; o_cmd.kind = esup_pkg::EV_OSC_BYTE; o_cmd.cmd_byte = ch;
                end
            end
            esup_pkg::ST_OSC_ST: begin
                n_state = esup_pkg::ST_NORMAL;
                o_cmd_valid = 1'b1;
                o_cmd.kind = (ch == "\\") ? esup_pkg::EV_OSC_END : esup_pkg::EV_OSC_ABRT;
            end
            esup_pkg::ST_PARAM, esup_pkg::ST_INTER: begin
                if (r_state == esup_pkg::ST_PARAM && ch inside {[8'h30:8'h3f]}) begin
                    if (ch == "?" && r_first) begin
                        n_q = 1'b1;
                    end else if (ch <= "9") begin
                        n_val = (mul > 20'hffff) ? 16'hffff : mul[15:0];
                        n_dig = 1'b1;
                    end else if (ch == ";") begin
                        close_req = 1'b1;
                        n_cnt = cnt_closed; n_val = '0; n_dig = 1'b0;
                    end else begin
                        n_bad = 1'b1;
                    end
                    n_first = 1'b0;
                end else begin
                    n_state = esup_pkg::ST_INTER;
                    if (ch inside {[8'h20:8'h2f]}) begin
                    end else if (ch inside {[8'h40:8'h7e]}) begin
                        close_req = 1'b1;
                        n_cnt = cnt_closed; n_val = '0; n_dig = 1'b0;
                        n_state = esup_pkg::ST_NORMAL; n_swallow = 1'b0;
                        if (!(r_swallow || r_bad)) begin
                            o_cmd_valid = 1'b1; o_cmd.run = 1'b1;
                            o_cmd.kind = esup_pkg::EV_CSI; o_cmd.cmd_byte = ch;
                            o_cmd.query = r_q; o_cmd.total = cnt_closed;
                        end
                    end else begin
                        n_state = esup_pkg::ST_NORMAL; n_swallow = 1'b0;
                    end
                end
            end
            esup_pkg::ST_U1, esup_pkg::ST_U2, esup_pkg::ST_U3: begin
                if (ch[7:6] != 2'b10) begin
                    n_state = esup_pkg::ST_NORMAL;
                    o_cmd_valid = 1'b1; o_cmd.kind = esup_pkg::EV_PRINT; o_cmd.char_val = 21'h25;
                end else begin
                    n_cp = {r_cp[14:0], ch[5:0]};
                    if (r_state == esup_pkg::ST_U1) begin
                        n_state = esup_pkg::ST_NORMAL;
                        o_cmd_valid = 1'b1; o_cmd.kind = esup_pkg::EV_PRINT;
                        o_cmd.char_val = n_cp;
                    end else if (r_state == esup_pkg::ST_U2) begin
                        n_state = esup_pkg::ST_U1;
                    end else begin
                        n_state = esup_pkg::ST_U2;
                    end
                end
            end
            default: norm = 1'b1;
        endcase
        if (norm) begin
            n_state = esup_pkg::ST_NORMAL;
            if (ch[7]) begin
                if (ch[7:5] == 3'b110) begin
                    n_state = esup_pkg::ST_U1; n_cp = {16'd0, ch[4:0]};
                end else if (ch[7:4] == 4'b1110) begin
                    n_state = esup_pkg::ST_U2; n_cp = {17'd0, ch[3:0]};
                end else if (ch[7:3] == 5'b11110) begin
                    n_state = esup_pkg::ST_U3; n_cp = {18'd0, ch[2:0]};
                end else begin
                    o_cmd_valid = 1'b1; o_cmd.kind = esup_pkg::EV_PRINT; o_cmd.char_val = 21'h25;
                end
            end else if (ch == 8'd0) begin
            end else if (ch == 8'd27) begin
                n_state = esup_pkg::ST_ESC; n_swallow = 1'b0;
            end else if (ch == 8'd8 || ch == 8'd7 || ch == 8'd9 || ch == 8'd13
                         || ch == 8'd10) begin
                o_cmd_valid = 1'b1; o_cmd.kind = esup_pkg::EV_CONTROL; o_cmd.cmd_byte = ch;
            end else begin
                o_cmd_valid = 1'b1; o_cmd.kind = esup_pkg::EV_PRINT; o_cmd.char_val = {13'd0, ch};
            end
        end
        o_cmd_valid = o_cmd_valid && take;
    end

    assign o_we    = take && close_req && r_dig && r_cnt < 5'(Cap);
    assign o_waddr = r_cnt[3:0];
    assign o_wdata = r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= esup_pkg::ST_NORMAL; r_cp <= '0; r_swallow <= 1'b0; r_q <= 1'b0;
            r_first <= 1'b1; r_val <= '0; r_dig <= 1'b0; r_bad <= 1'b0; r_cnt <= '0;
        end else if (take) begin
            r_state <= n_state; r_cp <= n_cp; r_swallow <= n_swallow; r_q <= n_q;
            r_first <= n_first; r_val <= n_val; r_dig <= n_dig; r_bad <= n_bad; r_cnt <= n_cnt;
        end
    end
endmodule

@@ rtl/esup_back.sv @@
module esup_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  esup_pkg::t_cmd   i_cmd,
    output logic             o_busy,
    output logic [3:0]       o_raddr,
    input  logic [15:0]      i_rdata,
    input  logic             i_out_ready,
    output logic             o_evt_valid,
    output esup_pkg::t_evt   o_evt
);
    // Run: issue read index k, data valid next cycle; each result waits for its data and a free output slot.
    logic           r_run, r_rd_pend;
    esup_pkg::t_cmd r_cmd;
    logic [4:0]     r_idx;
    logic           r_ov;
    esup_pkg::t_evt r_o;
    logic           slot;

    assign slot = !r_ov || i_out_ready;
    assign o_busy = r_run || (r_ov && !i_out_ready);
    assign o_raddr = r_idx[3:0];
    assign o_evt_valid = r_ov;
    assign o_evt = r_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0; r_rd_pend <= 1'b0; r_ov <= 1'b0; r_idx <= '0;
        end else begin
            if (slot) r_ov <= 1'b0;
            if (r_run) begin
                if (r_rd_pend && slot) begin
                    r_ov <= 1'b1;
                    r_o <= '{kind: esup_pkg::EV_CSI, char_val: '0, cmd_byte: r_cmd.cmd_byte,
                             query: r_cmd.query, index: r_idx[3:0], value: i_rdata,
                             total: r_cmd.total, last: (r_idx + 5'd1 == r_cmd.total)};
                    r_rd_pend <= 1'b0;
                    if (r_idx + 5'd1 == r_cmd.total) begin
                        r_run <= 1'b0;
                    end else begin
                        r_idx <= r_idx + 5'd1;
                    end
                end else if (!r_rd_pend) begin
                    r_rd_pend <= 1'b1;
                end
            end else if (i_cmd_valid && slot) begin
                if (i_cmd.run && i_cmd.total != 5'd0) begin
                    r_run <= 1'b1; r_cmd <= i_cmd; r_idx <= '0; r_rd_pend <= 1'b0;
                end else begin
                    r_ov <= 1'b1;
                    r_o <= '{kind: i_cmd.kind, char_val: i_cmd.char_val,
                             cmd_byte: i_cmd.cmd_byte, query: i_cmd.query, index: 4'd0,
                             value: 16'd0, total: 5'd0, last: i_cmd.run};
                end
            end
        end
    end
endmodule
